### rtl/siph_pkg.sv
package siph_pkg;

  localparam logic [63:0] INIT_C0   = 64'h736f6d6570736575;
  localparam logic [63:0] INIT_C1   = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT_C2   = 64'h6c7967656e657261;
  localparam logic [63:0] INIT_C3   = 64'h7465646279746573;
  localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

  // command queue depth
  localparam int unsigned CMD_DEPTH = 2;

  // round slots of one command: word compression, last block, finalization
  localparam logic [2:0] RND_WORD0 = 3'd0;
  localparam logic [2:0] RND_WORD1 = 3'd1;
  localparam logic [2:0] RND_BLK0  = 3'd2;
  localparam logic [2:0] RND_BLK1  = 3'd3;
  localparam logic [2:0] RND_LAST  = 3'd7;

  // configuration register indexes
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  typedef struct packed {
    logic        init;       // load lanes from key first
    logic        has_word;   // compress word as a full block
    logic        has_final;  // compress block, then finalize
    logic [63:0] word;
    logic [63:0] block;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic pop;
    logic load_hash;
  } back_stat_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic lanes_t sip_round(input lanes_t v);
    lanes_t t;
    t = v;
    t.v0 = t.v0 + t.v1;
    t.v1 = rotl(t.v1, 13);
    t.v1 = t.v1 ^ t.v0;
    t.v0 = rotl(t.v0, 32);
    t.v2 = t.v2 + t.v3;
    t.v3 = rotl(t.v3, 16);
    t.v3 = t.v3 ^ t.v2;
    t.v0 = t.v0 + t.v3;
    t.v3 = rotl(t.v3, 21);
    t.v3 = t.v3 ^ t.v0;
    t.v2 = t.v2 + t.v1;
    t.v1 = rotl(t.v1, 17);
    t.v1 = t.v1 ^ t.v2;
    t.v2 = rotl(t.v2, 32);
    return t;
  endfunction

endpackage

### rtl/siphash_keyed_hash.sv
// siphash-2-4 keyed hash engine
//
// input stream: one beat per 64-bit little-endian message word; tlast marks
// the final beat of a message, whose valid byte count (0 to 8, larger values
// count as 8) sits in tdata above the word. non-final beats always count as
// 8 bytes. output stream: one beat carrying the 64-bit hash per message.
// key: two 64-bit registers written through cfg_we_i / cfg_index_i /
// cfg_wdata_i (index 0 low half, index 1 high half); write only while idle,
// the key is sampled at the first word of each message.
//
// timing: the round core does one siphash round per cycle unless a waiting
// hash stalls it. a full word runs the word rounds, a final beat the last
// block and finalization rounds (word rounds first for an 8-byte last word).
// beats are registered in the command queue, which takes new words while
// the core is busy; the hash is valid the cycle after the last round.
//
// reset clears the queue, the byte count and the output valid flag; the next
// beat starts a new message. when the receiver stalls, the hash holds in the
// output register, the core stops at the last round of the next message and
// the two-entry queue fills before tready drops.
module siphash_keyed_hash
  import siph_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // message_word [63:0], valid_bytes [67:64], zeros
  input  logic        s_axis_tlast_i,   // last_word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // hash_value [63:0]
);

  logic [63:0] key_low_q, key_high_q;
  logic        push;
  cmd_t        push_cmd, head;
  fifo_stat_t  fifo_stat;
  back_stat_t  back_stat;

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= 64'd0;
      key_high_q <= 64'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        CFG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front: accepts beats, tracks message start and length, builds commands
  siph_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .fifo_stat_i     (fifo_stat),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  // short queue decoupling the front from the round core
  siph_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (back_stat.pop),
    .head_o      (head),
    .stat_o      (fifo_stat)
  );

  // back: rounds over the queue head, one per cycle unless stalled; hash output register
  siph_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .key_low_i       (key_low_q),
    .key_high_i      (key_high_q),
    .head_i          (head),
    .fifo_stat_i     (fifo_stat),
    .stat_o          (back_stat),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // the core never retires a command that is not there
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |-> !fifo_stat.empty)
    else $error("command popped from empty queue");

  // a command that ends a message always loads a hash when it retires
  a_final_loads_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_stat.pop && head.has_final) |-> back_stat.load_hash)
    else $error("final command retired without hash");

  // a new hash is never loaded over one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !back_stat.load_hash)
    else $error("pending hash overwritten");

endmodule

### rtl/siph_front.sv
module siph_front
  import siph_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  input  fifo_stat_t  fifo_stat_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic       start_q, start_d;
  logic [7:0] len_q, len_d;
  logic [3:0] cnt;
  logic [7:0] add;
  logic [63:0] word, masked;

  assign word            = s_axis_tdata_i[63:0];
  assign s_axis_tready_o = !fifo_stat_i.full;
  assign push_o          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    cnt = (s_axis_tdata_i[67:64] > 4'd8) ? 4'd8 : s_axis_tdata_i[67:64];
    add = s_axis_tlast_i ? {4'b0, cnt} : 8'd8;
    len_d = len_q + add;
    // partial bytes only when the last beat is short
    for (int i = 0; i < 8; i++) begin
      masked[i*8 +: 8] = ((4'(i) < cnt) && (cnt != 4'd8)) ? word[i*8 +: 8] : 8'h00;
    end
    cmd_o.init      = start_q;
    cmd_o.has_word  = !s_axis_tlast_i || (cnt == 4'd8);
    cmd_o.has_final = s_axis_tlast_i;
    cmd_o.word      = word;
    cmd_o.block     = {len_d, 56'b0} | masked;
    start_d         = s_axis_tlast_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      len_q   <= 8'd0;
    end else if (push_o) begin
      start_q <= start_d;
      len_q   <= start_d ? 8'd0 : len_d;
    end
  end

endmodule

### rtl/siph_cmd_fifo.sv
module siph_cmd_fifo
  import siph_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_t       push_data_i,
  input  logic       pop_i,
  output cmd_t       head_o,
  output fifo_stat_t stat_o
);

  localparam int unsigned PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             mem_q [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CNT_W'(CMD_DEPTH));
  assign stat_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/siph_back.sv
module siph_back
  import siph_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] key_low_i,
  input  logic [63:0] key_high_i,
  input  cmd_t        head_i,
  input  fifo_stat_t  fifo_stat_i,
  output back_stat_t  stat_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o
);

  lanes_t      lanes_q, lanes_d, base, pre, rnd;
  logic        active_q, active_d;
  logic [2:0]  rnd_q, rnd_d, rr, rend;
  logic        run, stall, done;
  logic        out_valid_q, out_valid_d;
  logic [63:0] hash_q;

  always_comb begin
    rr   = active_q ? rnd_q : (head_i.has_word ? RND_WORD0 : RND_BLK0);
    rend = head_i.has_final ? RND_LAST : RND_WORD1;

    // first round of a new message starts from the key
    if (!active_q && head_i.init) begin
      base.v0 = INIT_C0 ^ key_low_i;
      base.v1 = INIT_C1 ^ key_high_i;
      base.v2 = INIT_C2 ^ key_low_i;
      base.v3 = INIT_C3 ^ key_high_i;
    end else begin
      base = lanes_q;
    end

    pre = base;
    if (rr == RND_WORD0) begin
      pre.v3 = base.v3 ^ head_i.word;
    end else if (rr == RND_BLK0) begin
      pre.v3 = base.v3 ^ head_i.block;
    end

    rnd     = sip_round(pre);
    lanes_d = rnd;
    if (rr == RND_WORD1) begin
      lanes_d.v0 = rnd.v0 ^ head_i.word;
    end else if (rr == RND_BLK1) begin
      lanes_d.v0 = rnd.v0 ^ head_i.block;
      lanes_d.v2 = rnd.v2 ^ FINAL_XOR;
    end

    // hold the last round while the previous hash is still waiting
    stall = (rr == RND_LAST) && out_valid_q && !m_axis_tready_i;
    run   = !fifo_stat_i.empty && !stall;
    done  = run && (rr == rend);

    active_d = active_q;
    rnd_d    = rnd_q;
    if (run) begin
      active_d = !done;
      rnd_d    = rr + 3'd1;
    end

    stat_o.pop       = done;
    stat_o.load_hash = run && (rr == RND_LAST);

    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (stat_o.load_hash) begin
      out_valid_d = 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = hash_q;

  always_ff @(posedge clk_i) begin
    if (run) begin
      lanes_q <= lanes_d;
    end
    if (stat_o.load_hash) begin
      hash_q <= lanes_d.v0 ^ lanes_d.v1 ^ lanes_d.v2 ^ lanes_d.v3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      rnd_q       <= RND_WORD0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### dv/tb_siphash_keyed_hash.sv
`timescale 1ns / 1ps

module tb_siphash_keyed_hash;
  import siph_pkg::*;

  // clock period in ns and reset length in cycles
  localparam int unsigned CLK_PERIOD = 12;
  localparam int unsigned RESET_CYCLES = 12;
  // cycles with no beat, result or key write before the run is declared hung
  localparam int unsigned STALL_LIMIT = 4000;
  // worst case work still in flight once all hashes are out: two queued
  // words plus the round core and the output register
  localparam int unsigned SETTLE_CYCLES = 24;
  // cap on printed mismatch lines, all mismatches are still counted
  localparam int unsigned MAX_REPORTS = 40;
  // random beats per idling phase, three phases in all
  localparam int unsigned PHASE_BEATS = 630;

  // siphash initialization words and finalization constant
  localparam logic [63:0] SIP_IV0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_IV1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_IV2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_IV3 = 64'h7465646279746573;
  localparam logic [63:0] SIP_FIN = 64'h00000000000000ff;

  // dut inputs, all known from time zero
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_idx   = CFG_KEY_LOW;
  logic [63:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic [71:0] s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tready  = 1'b0;

  // dut outputs
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [63:0] m_axis_tdata;

  // idling odds in percent for the beat sender and the hash receiver
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;

  // predictor state: key registers, four lanes, byte count, start flag
  logic [63:0] key_lo = '0;
  logic [63:0] key_hi = '0;
  logic [63:0] hv0, hv1, hv2, hv3;
  logic [7:0]  byte_cnt  = '0;
  bit          new_msg   = 1'b1;

  // hashes predicted but not yet seen on the output stream
  logic [63:0] pending_hash_q[$];

  // run statistics
  int unsigned err_cnt     = 0;
  int unsigned beats_sent  = 0;
  int unsigned msgs_sent   = 0;
  int unsigned hashes_seen = 0;
  int unsigned key_writes  = 0;
  int unsigned idle_cycles = 0;

  siphash_keyed_hash u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // rotate left by shifting a doubled copy
  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    logic [127:0] dbl;
    dbl = {x, x} << r;
    return dbl[127:64];
  endfunction

  // one siphash round over the predicted lanes
  function automatic void sip_mix();
    hv0 = hv0 + hv1;
    hv1 = rotl64(hv1, 13) ^ hv0;
    hv0 = rotl64(hv0, 32);
    hv2 = hv2 + hv3;
    hv3 = rotl64(hv3, 16) ^ hv2;
    hv0 = hv0 + hv3;
    hv3 = rotl64(hv3, 21) ^ hv0;
    hv2 = hv2 + hv1;
    hv1 = rotl64(hv1, 17) ^ hv2;
    hv2 = rotl64(hv2, 32);
  endfunction

  // two-round compression of one 64-bit block
  function automatic void sip_absorb(input logic [63:0] blk);
    hv3 = hv3 ^ blk;
    sip_mix();
    sip_mix();
    hv0 = hv0 ^ blk;
  endfunction

  // advance the predicted hash state by one accepted beat; a final beat
  // closes the message and queues its hash
  function automatic void siphash_absorb_beat(input logic [63:0] word,
                                              input logic [3:0] nbytes,
                                              input logic last);
    logic [63:0] blk;
    int unsigned n;
    // key is sampled at the first word of a message only
    if (new_msg) begin
      hv0      = SIP_IV0 ^ key_lo;
      hv1      = SIP_IV1 ^ key_hi;
      hv2      = SIP_IV2 ^ key_lo;
      hv3      = SIP_IV3 ^ key_hi;
      byte_cnt = '0;
      new_msg  = 1'b0;
    end
    if (!last) begin
      // non-final word always counts as eight bytes
      sip_absorb(word);
      byte_cnt = byte_cnt + 8'd8;
    end else begin
      n = (nbytes > 4'd8) ? 8 : nbytes;
      if (n == 8) begin
        // full last word, the length byte then gets a block of its own
        sip_absorb(word);
        byte_cnt = byte_cnt + 8'd8;
        blk = '0;
      end else begin
        blk = (n == 0) ? 64'd0 : (word & ((64'd1 << (n * 8)) - 64'd1));
        byte_cnt = byte_cnt + 8'(n);
      end
      // at most seven data bytes, so the top byte is free for the length
      blk[63:56] = byte_cnt;
      sip_absorb(blk);
      hv2 = hv2 ^ SIP_FIN;
      repeat (4) sip_mix();
      pending_hash_q.push_back(hv0 ^ hv1 ^ hv2 ^ hv3);
      new_msg = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // every hash beat is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_tready) begin
      hashes_seen++;
      if (pending_hash_q.size() == 0) begin
        report_mismatch($sformatf("hash %h with no message pending", m_axis_tdata));
      end else begin
        if (m_axis_tdata !== pending_hash_q[0]) begin
          report_mismatch($sformatf("hash got %h want %h", m_axis_tdata,
                                    pending_hash_q[0]));
        end
        void'(pending_hash_q.pop_front());
      end
    end
  end

  // hash receiver, stalls at random with the current odds
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // hang detection: any beat, hash or key write restarts the count
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers, all entered right after a falling edge
  // ---------------------------------------------------------------------

  // send one message beat and return after the falling edge that follows
  // its acceptance; tvalid stays high so the next beat can go back to back
  task automatic send_beat(input logic [63:0] word, input logic [3:0] nbytes,
                           input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata  <= {4'b0000, nbytes, word};
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    siphash_absorb_beat(word, nbytes, last);
    beats_sent++;
    @(negedge clk);
  endtask

  // stop sending, wait for every hash, then let in-flight words finish
  task automatic wait_hashes_drained();
    s_tvalid <= 1'b0;
    while (pending_hash_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write enable is left high; the caller drops it after the last write
  task automatic write_cfg(input logic idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    if (idx == CFG_KEY_LOW) key_lo = val;
    else key_hi = val;
    key_writes++;
  endtask

  // keys only change with the block idle
  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
    wait_hashes_drained();
    write_cfg(CFG_KEY_LOW, lo);
    write_cfg(CFG_KEY_HIGH, hi);
    cfg_we <= 1'b0;
  endtask

  // random word biased toward edge patterns
  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // nwords beats in all, the last with final_nb valid bytes; valid_bytes on
  // the leading beats is random since it must be ignored there
  task automatic send_message(input int unsigned nwords, input logic [3:0] final_nb);
    for (int unsigned i = 1; i < nwords; i++) begin
      send_beat(rand_word(), 4'($urandom_range(15)), 1'b0);
    end
    send_beat(rand_word(), final_nb, 1'b1);
    msgs_sent++;
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // short messages under an all-zero key: empty, every last-beat size,
  // saturated sizes and a full last word
  task automatic test_short_messages();
    src_idle_pct  = 26;
    sink_idle_pct = 78;
    load_key('0, '0);
    send_message(1, 4'd0);
    send_beat('1, 4'd8, 1'b1);
    msgs_sent++;
    send_message(1, 4'd15);
    send_message(1, 4'd9);
    for (int unsigned nb = 1; nb < 8; nb++) begin
      send_message(1, 4'(nb));
    end
    // leading word with valid_bytes of zero still counts as eight bytes
    send_beat({$urandom, $urandom}, 4'd0, 1'b0);
    send_beat('1, 4'd8, 1'b1);
    msgs_sent++;
    send_beat('0, 4'd4, 1'b1);
    msgs_sent++;
  endtask

  // all-ones key at both halves
  task automatic test_key_all_ones();
    load_key('1, '1);
    send_message(1, 4'd0);
    send_message(1, 4'd8);
    send_message(3, 4'd5);
  endtask

  // key rewritten between words of one message only takes effect at the
  // next message
  task automatic test_key_change_midmsg();
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    send_beat(rand_word(), 4'($urandom_range(15)), 1'b0);
    send_beat(rand_word(), 4'($urandom_range(15)), 1'b0);
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    send_beat(rand_word(), 4'd6, 1'b1);
    msgs_sent++;
    send_message(2, 4'd3);
  endtask

  // random messages with random sizes under one key and one idling mix;
  // the first message is long enough to wrap the byte count
  task automatic test_random_stream(input int unsigned src_pct, input int unsigned sink_pct,
                                    input logic [63:0] lo, input logic [63:0] hi);
    int unsigned start_beats;
    int unsigned nwords;
    int unsigned pick;
    logic [3:0]  nb;
    load_key(lo, hi);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    start_beats   = beats_sent;
    send_message(33 + $urandom_range(7), 4'($urandom_range(15)));
    while (beats_sent - start_beats < PHASE_BEATS) begin
      pick = $urandom_range(99);
      if (pick < 60) nwords = $urandom_range(1, 4);
      else if (pick < 90) nwords = $urandom_range(5, 12);
      else nwords = $urandom_range(13, 40);
      if ($urandom_range(99) < 85) nb = 4'($urandom_range(8));
      else nb = 4'($urandom_range(9, 15));
      send_message(nwords, nb);
      // now and then hold off until the hash pipeline is empty
      if ($urandom_range(24) == 0) wait_hashes_drained();
    end
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_short_messages();
    test_key_all_ones();
    test_key_change_midmsg();
    test_random_stream(26, 78, {$urandom, $urandom}, {$urandom, $urandom});
    test_random_stream(78, 26, '0, {$urandom, $urandom});
    test_random_stream(0, 0, {$urandom, $urandom}, '1);

    wait_hashes_drained();

    $display("covered %0d beats in %0d messages with %0d key writes",
             beats_sent, msgs_sent, key_writes);
    $display("checked %0d hashes, %0d mismatches", hashes_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/siph_pkg.sv
rtl/siph_front.sv
rtl/siph_cmd_fifo.sv
rtl/siph_back.sv
rtl/siphash_keyed_hash.sv
dv/tb_siphash_keyed_hash.sv
